// ----- hw/rtl/des_pkg.sv -----
package des_pkg;

  typedef logic [27:0] half28_t;
  typedef logic [47:0] rkey_t;
  typedef logic [31:0] word_t;
  typedef logic [63:0] blk_t;

  localparam int NumRounds = 16;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_t;

  function automatic logic [6:0] ip_src(input int i);
    logic [6:0] t [64];
    t = '{7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
          7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
          7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
          7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
          7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
          7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
          7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
          7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7};
    return t[i];
  endfunction

  function automatic logic [6:0] fp_src(input int i);
    logic [6:0] t [64];
    t = '{7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
          7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
          7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
          7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
          7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
          7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
          7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
          7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25};
    return t[i];
  endfunction

  function automatic logic [6:0] pc1_src(input int i);
    logic [6:0] t [56];
    t = '{7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
          7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
          7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
          7'd60, 7'd52, 7'd44, 7'd36, 7'd63, 7'd55, 7'd47, 7'd39,
          7'd31, 7'd23, 7'd15, 7'd7,  7'd62, 7'd54, 7'd46, 7'd38,
          7'd30, 7'd22, 7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37,
          7'd29, 7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4};
    return t[i];
  endfunction

  function automatic logic [5:0] pc2_src(input int i);
    logic [5:0] t [48];
    t = '{6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
          6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
          6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
          6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
          6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
          6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32};
    return t[i];
  endfunction

  function automatic logic [5:0] exp_src(input int i);
    logic [5:0] t [48];
    t = '{6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,
          6'd6,  6'd7,  6'd8,  6'd9,  6'd8,  6'd9,  6'd10, 6'd11,
          6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
          6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21,
          6'd22, 6'd23, 6'd24, 6'd25, 6'd24, 6'd25, 6'd26, 6'd27,
          6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1};
    return t[i];
  endfunction

  function automatic logic [5:0] p_src(input int i);
    logic [5:0] t [32];
    t = '{6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
          6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
          6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
          6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25};
    return t[i];
  endfunction

  // cumulative left rotation after round i (1..16)
  function automatic logic [4:0] rot_total(input int i);
    logic [4:0] t [17];
    t = '{5'd0, 5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd12, 5'd14,
          5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd28};
    return t[i];
  endfunction

  function automatic logic [3:0] sbox(input int b, input logic [5:0] six);
    logic [3:0] t [8][64];
    logic [5:0] a;
    t = '{
      '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
        4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
        4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
        4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
      '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
        4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
        4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
        4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
      '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
        4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
        4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
        4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
      '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
        4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
        4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
        4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
      '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
        4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
        4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
        4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
      '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
        4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
        4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
        4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
      '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
        4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
        4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
        4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
      '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
        4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
        4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
        4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}};
    a = {six[5], six[0], six[4:1]};
    return t[b][a];
  endfunction

  function automatic blk_t perm_ip(input blk_t v);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - 32'(ip_src(i))];
    return r;
  endfunction

  function automatic blk_t perm_fp(input blk_t v);
    blk_t r;
    for (int i = 0; i < 64; i++) r[63-i] = v[64 - 32'(fp_src(i))];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input blk_t v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[64 - 32'(pc1_src(i))];
    return r;
  endfunction

  function automatic rkey_t perm_pc2(input logic [55:0] v);
    rkey_t r;
    for (int i = 0; i < 48; i++) r[47-i] = v[56 - 32'(pc2_src(i))];
    return r;
  endfunction

  function automatic half28_t rotl28(input half28_t x, input int s);
    logic [55:0] d;
    d = {x, x} << s;
    return d[55:28];
  endfunction

  // round key for round number k (0..15), from PC-1 output
  function automatic rkey_t round_key(input logic [55:0] cd, input int k);
    half28_t c;
    half28_t d;
    c = rotl28(cd[55:28], int'(rot_total(k + 1)));
    d = rotl28(cd[27:0], int'(rot_total(k + 1)));
    return perm_pc2({c, d});
  endfunction

  function automatic word_t feistel(input word_t h, input rkey_t k);
    rkey_t e;
    word_t acc;
    word_t r;
    for (int i = 0; i < 48; i++) e[47-i] = h[32 - 32'(exp_src(i))];
    e = e ^ k;
    for (int b = 0; b < 8; b++) acc[31-4*b -: 4] = sbox(b, e[47-6*b -: 6]);
    for (int i = 0; i < 32; i++) r[31-i] = acc[32 - 32'(p_src(i))];
    return r;
  endfunction

endpackage

// ----- hw/rtl/des_keysched.sv -----
module des_keysched
  import des_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] key,
  output rkey_t       rk [NumRounds]
);

  logic [55:0] cd_r;

  always_ff @(posedge clk) begin
    cd_r <= perm_pc1(key);
  end

  always_comb begin
    for (int k = 0; k < NumRounds; k++) rk[k] = round_key(cd_r, k);
  end

endmodule

// ----- hw/rtl/des_round.sv -----
module des_round
  import des_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  vld_i,
  input  logic  dec_i,
  input  word_t l_i,
  input  word_t r_i,
  input  rkey_t rk_enc,
  input  rkey_t rk_dec,
  output logic  vld_o,
  output logic  dec_o,
  output word_t l_o,
  output word_t r_o
);

  logic  vld_r;
  logic  dec_r;
  word_t l_r;
  word_t r_r;
  rkey_t k_sel;

  assign k_sel = dec_i ? rk_dec : rk_enc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    dec_r <= dec_i;
    l_r   <= r_i;
    r_r   <= l_i ^ feistel(r_i, k_sel);
  end

  assign vld_o = vld_r;
  assign dec_o = dec_r;
  assign l_o   = l_r;
  assign r_o   = r_r;

endmodule

// ----- hw/rtl/des_block_cipher_top.sv -----
// DES block cipher, ECB, one 64-bit block per beat.
// Input: drive in_opcode (0 encrypt, 1 decrypt) and in_block_in with start
// high; the beat is taken at a clock edge with start high and busy low.
// busy is always low, so a new block can enter every cycle.
// Output: out_block_out is valid for exactly one cycle while out_valid is
// high; the receiver cannot stall, results flow in input order.
// Path: a block passes through the input register, the sixteen round
// stages and the output register, in that order.
// Throughput: one block per cycle, set by the sixteen unrolled Feistel
// round stages.
// Key: cfg_we loads cfg_cipher_key; write only while the pipeline is empty.
// A block may enter at the very next edge: PC-1 of the key is registered
// at that edge, in time for the first round stage.
// Reset: rst_n (synchronous, active low) clears all valid bits and the key
// to zero; no item is in flight afterwards.
module des_block_cipher_top
  import des_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [63:0] in_block_in,
  input  logic        cfg_we,
  input  logic [63:0] cfg_cipher_key,
  output logic        out_valid,
  output logic [63:0] out_block_out
);

  logic [63:0] key_r;
  rkey_t       rk [NumRounds];

  logic        in_vld_r;
  logic        in_dec_r;
  word_t       in_l_r;
  word_t       in_r_r;

  logic        v  [NumRounds+1];
  logic        dc [NumRounds+1];
  word_t       lw [NumRounds+1];
  word_t       rw [NumRounds+1];

  logic        out_vld_r;
  blk_t        out_r;
  blk_t        ip_v;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else if (cfg_we) begin
      key_r <= cfg_cipher_key;
    end
  end

  des_keysched u_ks (
    .clk (clk),
    .key (key_r),
    .rk  (rk)
  );

  assign ip_v = perm_ip(in_block_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    in_dec_r <= in_opcode;
    in_l_r   <= ip_v[63:32];
    in_r_r   <= ip_v[31:0];
  end

  assign v[0]  = in_vld_r;
  assign dc[0] = in_dec_r;
  assign lw[0] = in_l_r;
  assign rw[0] = in_r_r;

  for (genvar g = 0; g < NumRounds; g++) begin : g_rnd
    des_round u_rnd (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (v[g]),
      .dec_i  (dc[g]),
      .l_i    (lw[g]),
      .r_i    (rw[g]),
      .rk_enc (rk[g]),
      .rk_dec (rk[NumRounds-1-g]),
      .vld_o  (v[g+1]),
      .dec_o  (dc[g+1]),
      .l_o    (lw[g+1]),
      .r_o    (rw[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= v[NumRounds];
    end
  end

  always_ff @(posedge clk) begin
    out_r <= perm_fp({rw[NumRounds], lw[NumRounds]});
  end

  assign out_valid     = out_vld_r;
  assign out_block_out = out_r;

endmodule
